FILE: hdl/vertex_attribute_to_float_assert.svh
// ----------------------------------------------------------------------------
// vertex attribute converter assertion macros
// wraps concurrent assertions so they can be compiled out
// ----------------------------------------------------------------------------
`ifndef VERTEX_ATTRIBUTE_TO_FLOAT_ASSERT_SVH
`define VERTEX_ATTRIBUTE_TO_FLOAT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VATF_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vatf assertion failed");
`define VATF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vatf assertion failed");
`else
`define VATF_ASSERT(name, cond)
`define VATF_ASSERT_IMPL(name, ante, cons)
`endif
`endif

FILE: hdl/vatf_pkg.sv
// ----------------------------------------------------------------------------
// vatf_pkg
// types, codes and helper functions of the vertex attribute converter
// ----------------------------------------------------------------------------
package vatf_pkg;

    // format codes on the input tuser
    typedef enum logic [2:0] {
        MODE_FLOAT32 = 3'd0,
        MODE_SNORM2  = 3'd1,
        MODE_SNORM4  = 3'd2,
        MODE_PACKED  = 3'd3,
        MODE_HALF2   = 3'd4,
        MODE_HALF4   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_PASS,
        KIND_DIV,
        KIND_HALF
    } lane_kind_t;

    // field width of a signed normalized value (divisor is 2^(w-1)-1 of it)
    typedef enum logic [1:0] {
        WID_16,
        WID_11,
        WID_10
    } wid_t;

    localparam logic [15:0] DIV_16 = 16'h7FFF;
    localparam logic [15:0] DIV_11 = 16'h03FF;
    localparam logic [15:0] DIV_10 = 16'h01FF;
    localparam logic [7:0]  EXP_ONE = 8'd127;
    localparam logic [7:0]  EXP_HALF_BIAS = 8'd112;

    typedef struct packed {
        lane_kind_t  kind;
        wid_t        wid;
        logic        sign;
        logic [15:0] val;
    } lane1_t;

    typedef struct packed {
        lane_kind_t  kind;
        logic        sign;
        logic [7:0]  expo;
        logic [22:0] mant;
        logic        rnd;
        logic [31:0] word;
    } lane2_t;

    // leading zeros of a 15-bit field, 15 when empty
    function automatic logic [3:0] clz15(input logic [14:0] v);
        logic [3:0] n;
        logic       found;
        n = 4'd15;
        found = 1'b0;
        for (int i = 14; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 4'(14 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // leading zeros of a 10-bit field
    function automatic logic [3:0] clz10(input logic [9:0] v);
        logic [3:0] n;
        logic       found;
        n = 4'd10;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 4'(9 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // half to single, exact
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  fr;
        logic [3:0]  lz;
        logic [10:0] sh;
        logic [31:0] res;
        ex = h[14:10];
        fr = h[9:0];
        lz = clz10(fr);
        sh = {1'b0, fr} << (lz + 4'd1);
        if (ex == 5'h1F)
            res = {h[15], 8'hFF, fr, 13'd0};
        else if (ex == 5'd0 && fr == 10'd0)
            res = {h[15], 31'd0};
        else if (ex == 5'd0)
            res = {h[15], EXP_HALF_BIAS - {4'd0, lz}, sh[9:0], 13'd0};
        else
            res = {h[15], {3'd0, ex} + EXP_HALF_BIAS, fr, 13'd0};
        return res;
    endfunction

    // magnitude over 2^(w-1)-1: the fraction of r/d repeats r's bits forever,
    // so the tail past the round bit is never zero and no tie can occur
    function automatic lane2_t div_prep(input lane1_t l);
        lane2_t      o;
        logic [15:0] d;
        logic        ip;
        logic [15:0] r;
        logic [47:0] pat;
        logic [3:0]  lz;
        logic [47:0] q;
        o = '0;
        unique case (l.wid)
            WID_16:  d = DIV_16;
            WID_11:  d = DIV_11;
            WID_10:  d = DIV_10;
            default: d = DIV_16;
        endcase
        ip = (l.val >= d);
        r = ip ? (l.val - d) : l.val;
        unique case (l.wid)
            WID_16:  pat = {r[14:0], r[14:0], r[14:0], r[14:12]};
            WID_11:  pat = {r[9:0], r[9:0], r[9:0], r[9:0], r[9:2]};
            WID_10:  pat = {r[8:0], r[8:0], r[8:0], r[8:0], r[8:0], r[8:6]};
            default: pat = '0;
        endcase
        lz = clz15(pat[47:33]);
        q = pat << lz;
        o.sign = l.sign;
        if (ip) begin
            o.kind = KIND_DIV;
            o.expo = EXP_ONE;
            o.mant = pat[47:25];
            o.rnd  = pat[24];
        end
        else if (r == 16'd0) begin
            o.kind = KIND_ZERO;
        end
        else begin
            o.kind = KIND_DIV;
            o.expo = EXP_ONE - 8'd1 - {4'd0, lz};
            o.mant = q[46:24];
            o.rnd  = q[23];
        end
        return o;
    endfunction

endpackage

FILE: hdl/vertex_attribute_to_float.sv
// ----------------------------------------------------------------------------
// vertex_attribute_to_float
// converts one packed vertex attribute word into up to four single floats
// ----------------------------------------------------------------------------
// Input stream: tdata carries the 64-bit attribute word, tuser the format
// code (float32, snorm16 x2/x4, packed s11/s11/s10, half x2/x4) and tlast
// marks the last word of a float32 array.
// Output stream: tdata carries the four components as single-precision bit
// patterns plus the count of meaningful components; unused components are
// zero, unknown format codes give all zeros and a count of zero. tlast is
// the input mark for float32 items and zero otherwise.
// Output tvalid rises once the item has passed the three register stages,
// and the item leaves when the receiver is ready. One item is accepted
// per cycle while the receiver does not stall; the snorm and packed
// divides need no divider since the divisors are all of the form 2^n-1,
// so each lane is a normalize and a round spread across the three register stages.
// Reset clears the stage valid bits only; the pipe comes up empty.
// When the receiver stalls, each stage keeps taking items until it is
// full, so up to three items are held before s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "vertex_attribute_to_float_assert.svh"

module vertex_attribute_to_float
    import vatf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // packed_word
    input  logic [2:0]   s_axis_tuser,   // mode
    input  logic         s_axis_tlast,   // final_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // comp_x, comp_y, comp_z, comp_w, valid_count
    output logic         m_axis_tlast    // final_out
);

    logic          v1_reg, v2_reg, v3_reg;
    logic          rdy1, rdy2, rdy3;
    lane1_t [3:0]  l1_reg, l1_next;
    logic [31:0]   pass1_reg, pass2_reg;
    logic [2:0]    cnt1_reg, cnt2_reg, cnt1_next;
    logic          last1_reg, last2_reg, last1_next;
    lane2_t [3:0]  l2_reg, l2_next;
    logic [135:0]  out_reg, out_next;
    logic          lastout_reg;

    // per-stage ready: a stage takes an item when empty or draining
    assign rdy3 = !v3_reg || m_axis_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    // stage 1: decode format into lanes, take magnitudes
    always_comb
    begin
        logic [15:0] h;
        logic [10:0] f11;
        logic [9:0]  f10;
        l1_next = '0;
        cnt1_next = 3'd0;
        last1_next = 1'b0;
        f11 = '0;
        f10 = '0;
        for (int i = 0; i < 4; i++) begin
            h = s_axis_tdata[16*i +: 16];
            unique case (s_axis_tuser)
                MODE_SNORM2, MODE_SNORM4:
                begin
                    if (i < 2 || s_axis_tuser == MODE_SNORM4) begin
                        l1_next[i].kind = KIND_DIV;
                        l1_next[i].wid  = WID_16;
                        l1_next[i].sign = h[15];
                        l1_next[i].val  = h[15] ? (~h + 16'd1) : h;
                    end
                end
                MODE_HALF2, MODE_HALF4:
                begin
                    if (i < 2 || s_axis_tuser == MODE_HALF4) begin
                        l1_next[i].kind = KIND_HALF;
                        l1_next[i].val  = h;
                    end
                end
                default:
                begin
                end
            endcase
        end
        unique case (s_axis_tuser)
            MODE_FLOAT32:
            begin
                l1_next[0].kind = KIND_PASS;
                cnt1_next = 3'd1;
                last1_next = s_axis_tlast;
            end
            MODE_SNORM2, MODE_HALF2: cnt1_next = 3'd2;
            MODE_SNORM4, MODE_HALF4: cnt1_next = 3'd4;
            MODE_PACKED:
            begin
                cnt1_next = 3'd3;
                for (int i = 0; i < 2; i++) begin
                    f11 = s_axis_tdata[11*i +: 11];
                    l1_next[i].kind = KIND_DIV;
                    l1_next[i].wid  = WID_11;
                    l1_next[i].sign = f11[10];
                    l1_next[i].val  = {5'd0, f11[10] ? (~f11 + 11'd1) : f11};
                end
                f10 = s_axis_tdata[31:22];
                l1_next[2].kind = KIND_DIV;
                l1_next[2].wid  = WID_10;
                l1_next[2].sign = f10[9];
                l1_next[2].val  = {6'd0, f10[9] ? (~f10 + 10'd1) : f10};
            end
            default: cnt1_next = 3'd0;
        endcase
    end

    // stage 2: normalize divide lanes, convert half lanes, forward the float32 lane
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            l2_next[i] = '0;
            unique case (l1_reg[i].kind)
                KIND_DIV:  l2_next[i] = div_prep(l1_reg[i]);
                KIND_HALF:
                begin
                    l2_next[i].kind = KIND_HALF;
                    l2_next[i].word = half_to_single(l1_reg[i].val);
                end
                KIND_PASS:
                begin
                    l2_next[i].kind = KIND_PASS;
                    l2_next[i].word = pass1_reg;
                end
                default: l2_next[i].kind = KIND_ZERO;
            endcase
        end
    end

    // stage 3: round and assemble output word
    always_comb
    begin
        logic [23:0] sum;
        logic [31:0] c;
        out_next = '0;
        for (int i = 0; i < 4; i++) begin
            sum = {1'b0, l2_reg[i].mant} + {23'd0, l2_reg[i].rnd};
            unique case (l2_reg[i].kind)
                KIND_DIV:  c = {l2_reg[i].sign, l2_reg[i].expo + {7'd0, sum[23]}, sum[22:0]};
                KIND_HALF, KIND_PASS: c = l2_reg[i].word;
                default:   c = 32'd0;
            endcase
            out_next[32*i +: 32] = c;
        end
        out_next[130:128] = cnt2_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid) begin
            l1_reg    <= l1_next;
            pass1_reg <= s_axis_tdata[31:0];
            cnt1_reg  <= cnt1_next;
            last1_reg <= last1_next;
        end
        if (rdy2 && v1_reg) begin
            l2_reg    <= l2_next;
            pass2_reg <= pass1_reg;
            cnt2_reg  <= cnt1_reg;
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg) begin
            out_reg     <= out_next;
            lastout_reg <= last2_reg;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = lastout_reg;

    // checks
    `VATF_ASSERT_IMPL(a_ready_only_when_full, !s_axis_tready, v1_reg && v2_reg && v3_reg)
    `VATF_ASSERT_IMPL(a_count_range, m_axis_tvalid, m_axis_tdata[130:128] <= 3'd4)
    `VATF_ASSERT_IMPL(a_err_zero, m_axis_tvalid && m_axis_tdata[130:128] == 3'd0,
        m_axis_tdata[127:0] == 128'd0)
    `VATF_ASSERT_IMPL(a_last_float, m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[130:128] == 3'd1)
    `VATF_ASSERT_IMPL(a_pass_lane, v2_reg && l2_reg[0].kind == KIND_PASS,
        l2_reg[0].word == pass2_reg)

endmodule
